/* hw/rtl/kev_pkg.sv */
// shared types and constants for the key edge voice allocator
`timescale 1ns / 1ps

package kev_pkg;

    localparam int LEVELS_W = 8;
    localparam int KEY_W = 3;
    localparam int VOICE_W = 3;
    localparam int VOICE_SLOTS = 8;
    localparam int DEFAULT_NUM_KEYS = 8;
    localparam int DEFAULT_NUM_VOICES = 8;

    typedef enum logic [1:0] {
        EV_ASSIGNED  = 2'd0,
        EV_NO_FREE   = 2'd1,
        EV_FREED     = 2'd2,
        EV_NONE_HELD = 2'd3
    } event_kind_t;

endpackage

/* hw/rtl/key_edge_voice_allocator_unit.sv */
// key edge voice allocator: scan edge detection and first-free voice assignment
//
// input channel s_*: one request per key scan, tdata holds one level bit per key
// (bit k set means key k pressed). keys at or above the key count are ignored.
// output channel m_*: one result per key edge, keys taken in ascending order;
// tdata = event_kind, key_index, voice_index; tlast marks the final result of a scan.
// a scan with no edges gives no result.
// after a scan is accepted a small sequencer walks the keys one per cycle,
// unless the output stalls, through one shared allocate/free unit.
// s_tready is high only between scans.
// the results sit in a single output register; if the receiver stalls, the
// walk holds at the next edge key until the register is taken. a new scan can
// be accepted while the last result of the previous one still waits.
// reset (aresetn low, synchronous): all keys released, all voices inactive,
// no result pending.
`timescale 1ns / 1ps

module key_edge_voice_allocator_unit #(
    parameter int NUM_KEYS = kev_pkg::DEFAULT_NUM_KEYS,
    parameter int NUM_VOICES = kev_pkg::DEFAULT_NUM_VOICES
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [kev_pkg::LEVELS_W-1:0]  s_tdata,   // key_levels[7:0]
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [7:0]                    m_tdata,   // event_kind[1:0], key_index[4:2], voice_index[7:5]
    output logic                          m_tlast    // last_of_scan
);

    localparam int KEY_LIMIT = (NUM_KEYS < kev_pkg::LEVELS_W) ? NUM_KEYS : kev_pkg::LEVELS_W;
    localparam int VOICE_LIMIT = (NUM_VOICES < kev_pkg::VOICE_SLOTS) ?
                                 NUM_VOICES : kev_pkg::VOICE_SLOTS;
    localparam logic [kev_pkg::LEVELS_W-1:0] KEY_MASK =
        kev_pkg::LEVELS_W'((9'd1 << KEY_LIMIT) - 9'd1);
    localparam logic [kev_pkg::VOICE_SLOTS-1:0] VOICE_MASK =
        kev_pkg::VOICE_SLOTS'((9'd1 << VOICE_LIMIT) - 9'd1);

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } state_t;

    state_t                              state_reg;
    logic [kev_pkg::LEVELS_W-1:0]        prev_levels_reg;
    logic [kev_pkg::LEVELS_W-1:0]        levels_reg;
    logic [kev_pkg::LEVELS_W-1:0]        edges_reg;
    logic [kev_pkg::KEY_W-1:0]           key_reg;
    logic [kev_pkg::VOICE_SLOTS-1:0]     busy_reg;
    logic [kev_pkg::VOICE_W-1:0]         owner_reg [kev_pkg::VOICE_SLOTS];
    logic                                m_tvalid_reg;
    logic [7:0]                          m_tdata_reg;
    logic                                m_tlast_reg;

    logic [kev_pkg::LEVELS_W-1:0]        levels_in;
    logic [kev_pkg::LEVELS_W-1:0]        edges_next;
    logic [kev_pkg::VOICE_SLOTS-1:0]     free_mask;
    logic [kev_pkg::VOICE_SLOTS-1:0]     held_mask;
    logic [kev_pkg::VOICE_W-1:0]         free_idx;
    logic [kev_pkg::VOICE_W-1:0]         held_idx;
    logic                                cur_edge;
    logic                                cur_press;
    logic                                load;
    logic                                advance;
    logic                                accept;
    kev_pkg::event_kind_t                kind_next;
    logic [kev_pkg::VOICE_W-1:0]         voice_next;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept = s_tvalid && s_tready;
    assign levels_in = s_tdata & KEY_MASK;

    assign cur_edge = (state_reg == ST_SCAN) && edges_reg[key_reg];
    assign cur_press = levels_reg[key_reg];
    assign load = cur_edge && (!m_tvalid_reg || m_tready);
    assign advance = (state_reg == ST_SCAN) && (!edges_reg[key_reg] || load);

    // shared allocate/free unit: lowest free voice, lowest voice held by the key
    always_comb begin
        free_mask = ~busy_reg & VOICE_MASK;
        held_mask = '0;
        free_idx = '0;
        held_idx = '0;
        for (int v = 0; v < kev_pkg::VOICE_SLOTS; v++) begin
            held_mask[v] = busy_reg[v] && (owner_reg[v] == key_reg);
        end
        for (int v = kev_pkg::VOICE_SLOTS - 1; v >= 0; v--) begin
            if (free_mask[v]) begin
                free_idx = kev_pkg::VOICE_W'(v);
            end
            if (held_mask[v]) begin
                held_idx = kev_pkg::VOICE_W'(v);
            end
        end
    end

    always_comb begin
        if (cur_press) begin
            if (free_mask != '0) begin
                kind_next = kev_pkg::EV_ASSIGNED;
                voice_next = free_idx;
            end else begin
                kind_next = kev_pkg::EV_NO_FREE;
                voice_next = '0;
            end
        end else begin
            if (held_mask != '0) begin
                kind_next = kev_pkg::EV_FREED;
                voice_next = held_idx;
            end else begin
                kind_next = kev_pkg::EV_NONE_HELD;
                voice_next = '0;
            end
        end
        edges_next = edges_reg;
        if (advance) begin
            edges_next[key_reg] = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            prev_levels_reg <= '0;
            edges_reg <= '0;
            key_reg <= '0;
            busy_reg <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        prev_levels_reg <= levels_in;
                        levels_reg <= levels_in;
                        edges_reg <= (levels_in ^ prev_levels_reg) & KEY_MASK;
                        key_reg <= '0;
                        if (((levels_in ^ prev_levels_reg) & KEY_MASK) != '0) begin
                            state_reg <= ST_SCAN;
                        end
                    end
                end
                ST_SCAN: begin
                    if (advance) begin
                        edges_reg <= edges_next;
                        key_reg <= key_reg + kev_pkg::KEY_W'(1);
                        if (edges_next == '0) begin
                            state_reg <= ST_IDLE;
                        end
                    end
                    if (load) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg <= {voice_next, key_reg, kind_next};
                        m_tlast_reg <= (edges_next == '0);
                        if (kind_next == kev_pkg::EV_ASSIGNED) begin
                            busy_reg[free_idx] <= 1'b1;
                            owner_reg[free_idx] <= key_reg;
                        end else if (kind_next == kev_pkg::EV_FREED) begin
                            busy_reg <= busy_reg & ~held_mask;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata = m_tdata_reg;
    assign m_tlast = m_tlast_reg;

    a_busy_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (busy_reg & ~VOICE_MASK) == '0)
        else $error("voice beyond the voice count marked busy");

    a_scan_has_edges: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SCAN |-> edges_reg != '0)
        else $error("scan walk running with no edge left");

    a_prev_levels: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> prev_levels_reg == $past(levels_in))
        else $error("previous levels not updated from accepted scan");

    a_assign_marks_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        load && kind_next == kev_pkg::EV_ASSIGNED |=> busy_reg[$past(free_idx)])
        else $error("assigned voice not marked busy");

    a_free_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        load && kind_next == kev_pkg::EV_FREED |=> (busy_reg & $past(held_mask)) == '0)
        else $error("released voice still busy");

endmodule

/* tb/testbench.sv */
// self-checking testbench for the key edge voice allocator unit
`timescale 1ns / 1ps

module testbench;

    localparam int KEYS = kev_pkg::DEFAULT_NUM_KEYS;
    localparam int VOICES = kev_pkg::DEFAULT_NUM_VOICES;
    localparam int KEY_LIMIT = (KEYS < kev_pkg::LEVELS_W) ? KEYS : kev_pkg::LEVELS_W;
    localparam int VOICE_LIMIT = (VOICES < kev_pkg::VOICE_SLOTS) ? VOICES : kev_pkg::VOICE_SLOTS;
    localparam logic [kev_pkg::LEVELS_W-1:0] KEY_MASK =
        kev_pkg::LEVELS_W'((1 << KEY_LIMIT) - 1);
    localparam int RANDOM_SCANS = 200;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_PERIOD = 1200;
    localparam int HOLD_START = 400;
    localparam int HOLD_LENGTH = 160;

    typedef struct {
        kev_pkg::event_kind_t          kind;
        logic [kev_pkg::KEY_W-1:0]     key;
        logic [kev_pkg::VOICE_W-1:0]   voice;
        logic                          last;
    } voice_event_t;

    typedef struct {
        logic [kev_pkg::LEVELS_W-1:0]  levels;
        bit                            wait_drain;
    } key_scan_t;

    logic                          aclk = 1'b0;
    logic                          aresetn = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [kev_pkg::LEVELS_W-1:0]  s_tdata = '0;      // key_levels[7:0]
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [7:0]                    m_tdata;           // event_kind[1:0], key_index[4:2], voice_index[7:5]
    logic                          m_tlast;           // last_of_scan

    key_scan_t            scan_queue[$];
    voice_event_t         voice_events_due[$];

    logic [kev_pkg::LEVELS_W-1:0]  held_levels = '0;
    logic                          voice_active[kev_pkg::VOICE_SLOTS];
    logic [kev_pkg::KEY_W-1:0]     voice_key[kev_pkg::VOICE_SLOTS];

    logic                 s_taken = 1'b0;
    int                   gap_left = 0;
    int                   burst_left = 0;
    int                   rx_cycle = 0;
    int                   rx_mode = 0;
    int                   stall_cycles = 0;
    int                   error_count = 0;
    voice_event_t         seen_event;
    voice_event_t         due_event;

    key_edge_voice_allocator_unit #(
        .NUM_KEYS   (KEYS),
        .NUM_VOICES (VOICES)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // edge detection and first-free voice allocation for one accepted scan
    function automatic void allocate_scan(input logic [kev_pkg::LEVELS_W-1:0] raw_levels);
        logic [kev_pkg::LEVELS_W-1:0] levels;
        int edge_total;
        int edge_no;
        int found;
        voice_event_t ev;
        levels = raw_levels & KEY_MASK;
        edge_total = $countones(levels ^ held_levels);
        edge_no = 0;
        for (int k = 0; k < KEY_LIMIT; k++) begin
            if (levels[k] != held_levels[k]) begin
                found = -1;
                ev.key = kev_pkg::KEY_W'(k);
                if (levels[k]) begin
                    for (int v = 0; v < VOICE_LIMIT; v++) begin
                        if (!voice_active[v] && found < 0) begin
                            found = v;
                        end
                    end
                    if (found >= 0) begin
                        voice_active[found] = 1'b1;
                        voice_key[found] = kev_pkg::KEY_W'(k);
                        ev.kind = kev_pkg::EV_ASSIGNED;
                        ev.voice = kev_pkg::VOICE_W'(found);
                    end else begin
                        ev.kind = kev_pkg::EV_NO_FREE;
                        ev.voice = '0;
                    end
                end else begin
                    for (int v = 0; v < VOICE_LIMIT; v++) begin
                        if (voice_active[v] && voice_key[v] == kev_pkg::KEY_W'(k)) begin
                            voice_active[v] = 1'b0;
                            if (found < 0) begin
                                found = v;
                            end
                        end
                    end
                    if (found >= 0) begin
                        ev.kind = kev_pkg::EV_FREED;
                        ev.voice = kev_pkg::VOICE_W'(found);
                    end else begin
                        ev.kind = kev_pkg::EV_NONE_HELD;
                        ev.voice = '0;
                    end
                end
                edge_no++;
                ev.last = (edge_no == edge_total);
                voice_events_due.push_back(ev);
            end
        end
        held_levels = levels;
    endfunction

    task automatic add_scan(input logic [kev_pkg::LEVELS_W-1:0] levels, input bit wait_drain);
        key_scan_t scan;
        scan.levels = levels;
        scan.wait_drain = wait_drain;
        scan_queue.push_back(scan);
    endtask

    // stimulus
    initial begin
        logic [kev_pkg::LEVELS_W-1:0] lv;
        int counted;
        int pick;
        int flips;
        for (int v = 0; v < kev_pkg::VOICE_SLOTS; v++) begin
            voice_active[v] = 1'b0;
            voice_key[v] = '0;
        end
        add_scan(8'h00, 1'b0);
        add_scan(8'h01, 1'b0);
        add_scan(8'h03, 1'b0);
        add_scan(8'h02, 1'b0);
        add_scan(8'hff, 1'b0);
        add_scan(8'hff, 1'b0);
        add_scan(8'h00, 1'b0);
        add_scan(8'hff, 1'b1);
        add_scan(8'h7f, 1'b0);
        add_scan(8'hff, 1'b0);
        add_scan(8'hfe, 1'b0);
        add_scan(8'h00, 1'b0);
        add_scan(8'h80, 1'b0);
        add_scan(8'h81, 1'b0);
        add_scan(8'h01, 1'b0);
        add_scan(8'h55, 1'b0);
        add_scan(8'haa, 1'b0);
        add_scan(8'h0f, 1'b0);
        add_scan(8'hf0, 1'b0);
        add_scan(8'h00, 1'b0);
        lv = 8'h00;
        counted = 0;
        while (counted < RANDOM_SCANS) begin
            pick = $urandom_range(0, 9);
            if (pick <= 5) begin
                flips = $urandom_range(1, 3);
                for (int j = 0; j < flips; j++) begin
                    lv[$urandom_range(0, kev_pkg::LEVELS_W - 1)] ^= 1'b1;
                end
            end else if (pick == 7) begin
                lv = kev_pkg::LEVELS_W'($urandom_range(0, 255));
            end else if (pick == 8) begin
                lv = ($urandom_range(0, 1) == 0) ? 8'h00 : 8'hff;
            end else if (pick == 9) begin
                lv[$urandom_range(0, kev_pkg::LEVELS_W - 1)] ^= 1'b1;
            end
            add_scan(lv, counted == RANDOM_SCANS / 2);
            counted++;
        end
    end

    // scan driver: bursts with random gaps
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
        end else if (!s_tvalid || s_taken) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                s_tvalid <= 1'b0;
            end else if (scan_queue.size() == 0 ||
                         (scan_queue[0].wait_drain && voice_events_due.size() != 0)) begin
                s_tvalid <= 1'b0;
            end else begin
                s_tvalid <= 1'b1;
                s_tdata <= scan_queue[0].levels;
                scan_queue.pop_front();
                if (burst_left == 0) begin
                    burst_left <= $urandom_range(1, 16);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end
        end
    end

    // result receiver: rotating stall patterns plus a periodic long hold
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            rx_cycle <= rx_cycle + 1;
            if (rx_cycle % 64 == 0) begin
                rx_mode <= $urandom_range(0, 3);
            end
            if (rx_cycle % HOLD_PERIOD >= HOLD_START &&
                rx_cycle % HOLD_PERIOD < HOLD_START + HOLD_LENGTH) begin
                m_tready <= 1'b0;
            end else begin
                case (rx_mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= ($urandom_range(0, 1) == 1);
                    2: m_tready <= ($urandom_range(0, 3) != 0);
                    default: m_tready <= (rx_cycle % 3 == 0);
                endcase
            end
        end
    end

    // monitor, checker and watchdog
    always @(posedge aclk) begin
        s_taken <= s_tvalid && s_tready;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                allocate_scan(s_tdata);
            end
            if (m_tvalid && m_tready) begin
                seen_event.kind = kev_pkg::event_kind_t'(m_tdata[1:0]);
                seen_event.key = m_tdata[4:2];
                seen_event.voice = m_tdata[7:5];
                seen_event.last = m_tlast;
                if (voice_events_due.size() == 0) begin
                    $error("unexpected result: event_kind %0d key_index %0d voice_index %0d",
                           seen_event.kind, seen_event.key, seen_event.voice);
                    error_count++;
                end else begin
                    due_event = voice_events_due.pop_front();
                    if (seen_event.kind !== due_event.kind) begin
                        $error("event_kind: expected %0d, got %0d",
                               due_event.kind, seen_event.kind);
                        error_count++;
                    end
                    if (seen_event.key !== due_event.key) begin
                        $error("key_index: expected %0d, got %0d",
                               due_event.key, seen_event.key);
                        error_count++;
                    end
                    if (seen_event.voice !== due_event.voice) begin
                        $error("voice_index: expected %0d, got %0d",
                               due_event.voice, seen_event.voice);
                        error_count++;
                    end
                    if (seen_event.last !== due_event.last) begin
                        $error("last_of_scan: expected %0d, got %0d",
                               due_event.last, seen_event.last);
                        error_count++;
                    end
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                stall_cycles <= 0;
            end else if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    // reset, drain and verdict
    initial begin
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        while (scan_queue.size() != 0 || s_tvalid) begin
            @(posedge aclk);
        end
        while (voice_events_due.size() != 0) begin
            @(posedge aclk);
        end
        repeat (20) @(posedge aclk);
        if (voice_events_due.size() != 0) begin
            $error("results missing: %0d still expected", voice_events_due.size());
            error_count++;
        end
        if (error_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
